FILE: rtl/olidf_pkg.sv
// package for the ordered list block: field widths, action and status codes,
// micro-op and jump-condition codes, and the control store with its dispatch map
// depends on nothing
package olidf_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int ACT_W         = 3;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 8;
   localparam int STATUS_W      = 2;
   localparam int UPC_W         = 5;

   // request action codes
   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR  = 3'd0,
      ACT_APPEND = 3'd1,
      ACT_INSERT = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_FIND   = 3'd4
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADPOS   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // datapath micro-ops, one per control word
   typedef enum logic [4:0] {
      UOP_NOP,
      UOP_ACCEPT,
      UOP_RESPOND,
      UOP_COUNT_CLR,
      UOP_COUNT_DEC,
      UOP_WRITE_APPEND,
      UOP_WRITE_VAL_POS,
      UOP_LOAD_IDX_COUNT,
      UOP_LOAD_IDX_POS,
      UOP_LOAD_IDX_ZERO,
      UOP_READ_PREV,
      UOP_READ_NEXT,
      UOP_READ_CUR,
      UOP_WRITE_UP,
      UOP_WRITE_DOWN,
      UOP_IDX_INC,
      UOP_SET_FOUND,
      UOP_SET_FULL,
      UOP_SET_BADPOS,
      UOP_SET_NOTFOUND
   } uop_type;

   // jump conditions: taken goes to target, else to the next step; dispatch goes to the action's routine or holds
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_FULL,
      COND_INS_BAD,
      COND_DEL_BAD,
      COND_INS_DONE,
      COND_DEL_DONE,
      COND_FIND_END,
      COND_NO_MATCH,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [UPC_W-1:0] upc_type;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   // step addresses; respond sits right before idle so it falls through
   localparam upc_type UPC_RSP      = 5'd0;
   localparam upc_type UPC_IDLE     = 5'd1;
   localparam upc_type UPC_CLR      = 5'd2;
   localparam upc_type UPC_APP      = 5'd3;
   localparam upc_type UPC_APP_PUT  = 5'd4;
   localparam upc_type UPC_INS      = 5'd5;
   localparam upc_type UPC_INS_CHK  = 5'd6;
   localparam upc_type UPC_INS_LOOP = 5'd7;
   localparam upc_type UPC_INS_MOVE = 5'd8;
   localparam upc_type UPC_INS_PUT  = 5'd9;
   localparam upc_type UPC_DEL      = 5'd10;
   localparam upc_type UPC_DEL_LOOP = 5'd11;
   localparam upc_type UPC_DEL_MOVE = 5'd12;
   localparam upc_type UPC_DEL_END  = 5'd13;
   localparam upc_type UPC_FND      = 5'd14;
   localparam upc_type UPC_FND_LOOP = 5'd15;
   localparam upc_type UPC_FND_CMP  = 5'd16;
   localparam upc_type UPC_FND_HIT  = 5'd17;
   localparam upc_type UPC_SFULL    = 5'd18;
   localparam upc_type UPC_SNF      = 5'd19;
   localparam upc_type UPC_SBAD     = 5'd20;

   function automatic ctrl_word_type cw_make(input uop_type op, input cond_type cond,
                                             input upc_type target);
      ctrl_word_type cw;
      cw.op     = op;
      cw.cond   = cond;
      cw.target = target;
      return cw;
   endfunction

   // control store
   function automatic ctrl_word_type ucode_rom(input upc_type addr);
      ctrl_word_type cw;
      case (addr)
         UPC_RSP:      cw = cw_make(UOP_RESPOND,        COND_OUT_BUSY, UPC_RSP);
         UPC_IDLE:     cw = cw_make(UOP_ACCEPT,         COND_DISPATCH, UPC_IDLE);
         UPC_CLR:      cw = cw_make(UOP_COUNT_CLR,      COND_ALWAYS,   UPC_RSP);
         UPC_APP:      cw = cw_make(UOP_NOP,            COND_FULL,     UPC_SFULL);
         UPC_APP_PUT:  cw = cw_make(UOP_WRITE_APPEND,   COND_ALWAYS,   UPC_RSP);
         UPC_INS:      cw = cw_make(UOP_NOP,            COND_FULL,     UPC_SFULL);
         UPC_INS_CHK:  cw = cw_make(UOP_LOAD_IDX_COUNT, COND_INS_BAD,  UPC_SBAD);
         UPC_INS_LOOP: cw = cw_make(UOP_READ_PREV,      COND_INS_DONE, UPC_INS_PUT);
         UPC_INS_MOVE: cw = cw_make(UOP_WRITE_UP,       COND_ALWAYS,   UPC_INS_LOOP);
         UPC_INS_PUT:  cw = cw_make(UOP_WRITE_VAL_POS,  COND_ALWAYS,   UPC_RSP);
         UPC_DEL:      cw = cw_make(UOP_LOAD_IDX_POS,   COND_DEL_BAD,  UPC_SBAD);
         UPC_DEL_LOOP: cw = cw_make(UOP_READ_NEXT,      COND_DEL_DONE, UPC_DEL_END);
         UPC_DEL_MOVE: cw = cw_make(UOP_WRITE_DOWN,     COND_ALWAYS,   UPC_DEL_LOOP);
         UPC_DEL_END:  cw = cw_make(UOP_COUNT_DEC,      COND_ALWAYS,   UPC_RSP);
         UPC_FND:      cw = cw_make(UOP_LOAD_IDX_ZERO,  COND_NEVER,    UPC_FND);
         UPC_FND_LOOP: cw = cw_make(UOP_READ_CUR,       COND_FIND_END, UPC_SNF);
         UPC_FND_CMP:  cw = cw_make(UOP_IDX_INC,        COND_NO_MATCH, UPC_FND_LOOP);
         UPC_FND_HIT:  cw = cw_make(UOP_SET_FOUND,      COND_ALWAYS,   UPC_RSP);
         UPC_SFULL:    cw = cw_make(UOP_SET_FULL,       COND_ALWAYS,   UPC_RSP);
         UPC_SNF:      cw = cw_make(UOP_SET_NOTFOUND,   COND_ALWAYS,   UPC_RSP);
         UPC_SBAD:     cw = cw_make(UOP_SET_BADPOS,     COND_ALWAYS,   UPC_RSP);
         default:      cw = cw_make(UOP_NOP,            COND_ALWAYS,   UPC_IDLE);
      endcase
      return cw;
   endfunction

   // first step of each action's routine; unused codes answer at once
   function automatic upc_type dispatch(input logic [ACT_W-1:0] action);
      upc_type target;
      case (action)
         ACT_CLEAR:  target = UPC_CLR;
         ACT_APPEND: target = UPC_APP;
         ACT_INSERT: target = UPC_INS;
         ACT_DELETE: target = UPC_DEL;
         ACT_FIND:   target = UPC_FND;
         default:    target = UPC_RSP;
      endcase
      return target;
   endfunction

endpackage

FILE: rtl/ordered_list_insert_delete_find.sv
// ordered list with positional insert, delete and find, run by a microcoded sequencer
// one request at a time: req_stall stays high from acceptance until the result is loaded into
// the output register, and the respond step waits while that register is stalled; insert and
// delete shift the entries one by one, find scans from the front to the first match or the end
// reset (synchronous) empties the list and idles the sequencer; entry storage is not cleared
// depends on olidf_pkg
module ordered_list_insert_delete_find #(
   parameter int DEPTH = olidf_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [olidf_pkg::ACT_W-1:0]         req_action,
   input  logic signed [olidf_pkg::VALUE_W-1:0] req_value,
   input  logic [olidf_pkg::POS_W-1:0]         req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [olidf_pkg::STATUS_W-1:0]      rsp_status,
   output logic [olidf_pkg::POS_W-1:0]         rsp_found_position,
   output logic [olidf_pkg::POS_W-1:0]         rsp_count
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int AW   = $clog2(DEPTH);
   localparam int CMPW = ((CW > olidf_pkg::POS_W) ? CW : olidf_pkg::POS_W) + 1;

   olidf_pkg::upc_type       pc_ff, pc_in;
   olidf_pkg::ctrl_word_type cw;
   logic                     cond_hit;
   logic                     accept;
   logic                     out_busy;

   logic signed [olidf_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [olidf_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [CW-1:0]                        idx_ff, idx_in;
   olidf_pkg::status_type                status_ff, status_in;
   logic [olidf_pkg::POS_W-1:0]          found_ff, found_in;

   logic [olidf_pkg::VALUE_W-1:0] entries [DEPTH];
   logic [olidf_pkg::VALUE_W-1:0] rdata_ff;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [olidf_pkg::VALUE_W-1:0] mem_wdata;
   logic                          mem_re;
   logic [AW-1:0]                 mem_raddr;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_load;
   olidf_pkg::status_type               rsp_status_ff;
   logic [olidf_pkg::POS_W-1:0]         rsp_found_ff;
   logic [olidf_pkg::POS_W-1:0]         rsp_count_ff;

   logic [CMPW-1:0] pos_x, cnt_x, idx_x;
   logic [CMPW-1:0] idx_m1, idx_p1, pos_m1;

   // control word fetch
   always_comb begin
      cw = olidf_pkg::ucode_rom(pc_ff);
   end

   // widened operands for compares and addresses
   assign pos_x  = CMPW'(pos_ff);
   assign cnt_x  = CMPW'(count_ff);
   assign idx_x  = CMPW'(idx_ff);
   assign idx_m1 = idx_x - CMPW'(1);
   assign idx_p1 = idx_x + CMPW'(1);
   assign pos_m1 = pos_x - CMPW'(1);

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (cw.op != olidf_pkg::UOP_ACCEPT);
   assign accept    = req_valid && !req_stall;

   // jump condition select
   always_comb begin
      case (cw.cond)
         olidf_pkg::COND_NEVER:     cond_hit = 1'b0;
         olidf_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         olidf_pkg::COND_FULL:      cond_hit = (cnt_x >= CMPW'(DEPTH));
         olidf_pkg::COND_INS_BAD:   cond_hit = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));
         olidf_pkg::COND_DEL_BAD:   cond_hit = (pos_x == '0) || (pos_x > cnt_x);
         olidf_pkg::COND_INS_DONE:  cond_hit = (idx_x < pos_x);
         olidf_pkg::COND_DEL_DONE:  cond_hit = (idx_p1 >= cnt_x);
         olidf_pkg::COND_FIND_END:  cond_hit = (idx_x >= cnt_x);
         olidf_pkg::COND_NO_MATCH:  cond_hit = (rdata_ff != val_ff);
         olidf_pkg::COND_OUT_BUSY:  cond_hit = out_busy;
         default:                   cond_hit = 1'b0;
      endcase
   end

   // step counter: dispatch on the action, jump, or step on
   always_comb begin
      if (cw.cond == olidf_pkg::COND_DISPATCH) begin
         pc_in = accept ? olidf_pkg::dispatch(req_action) : pc_ff;
      end else if (cond_hit) begin
         pc_in = cw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // datapath driven by the micro-op
   always_comb begin
      val_in    = val_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      found_in  = found_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = rdata_ff;
      mem_re    = 1'b0;
      mem_raddr = idx_ff[AW-1:0];
      rsp_load  = 1'b0;
      case (cw.op)
         olidf_pkg::UOP_ACCEPT: begin
            if (accept) begin
               val_in    = req_value;
               pos_in    = req_position;
               status_in = olidf_pkg::ST_OK;
               found_in  = '0;
            end
         end
         olidf_pkg::UOP_RESPOND:        rsp_load = !out_busy;
         olidf_pkg::UOP_COUNT_CLR:      count_in = '0;
         olidf_pkg::UOP_COUNT_DEC:      count_in = count_ff - 1'b1;
         olidf_pkg::UOP_WRITE_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = count_ff[AW-1:0];
            mem_wdata = val_ff;
            count_in  = count_ff + 1'b1;
         end
         olidf_pkg::UOP_WRITE_VAL_POS: begin
            mem_we    = 1'b1;
            mem_waddr = pos_m1[AW-1:0];
            mem_wdata = val_ff;
            count_in  = count_ff + 1'b1;
         end
         olidf_pkg::UOP_LOAD_IDX_COUNT: idx_in = count_ff;
         olidf_pkg::UOP_LOAD_IDX_POS:   idx_in = pos_m1[CW-1:0];
         olidf_pkg::UOP_LOAD_IDX_ZERO:  idx_in = '0;
         olidf_pkg::UOP_READ_PREV: begin
            mem_re    = 1'b1;
            mem_raddr = idx_m1[AW-1:0];
         end
         olidf_pkg::UOP_READ_NEXT: begin
            mem_re    = 1'b1;
            mem_raddr = idx_p1[AW-1:0];
         end
         olidf_pkg::UOP_READ_CUR:       mem_re = 1'b1;
         olidf_pkg::UOP_WRITE_UP: begin
            mem_we = 1'b1;
            idx_in = idx_m1[CW-1:0];
         end
         olidf_pkg::UOP_WRITE_DOWN: begin
            mem_we = 1'b1;
            idx_in = idx_p1[CW-1:0];
         end
         olidf_pkg::UOP_IDX_INC:        idx_in = idx_p1[CW-1:0];
         // index already moved past the hit, so it is the 1-based position
         olidf_pkg::UOP_SET_FOUND:      found_in = olidf_pkg::POS_W'(idx_ff);
         olidf_pkg::UOP_SET_FULL:       status_in = olidf_pkg::ST_FULL;
         olidf_pkg::UOP_SET_BADPOS:     status_in = olidf_pkg::ST_BADPOS;
         olidf_pkg::UOP_SET_NOTFOUND:   status_in = olidf_pkg::ST_NOTFOUND;
         default: begin
         end
      endcase
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= entries[mem_raddr];
      end
   end

   // sequencer and list control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= olidf_pkg::UPC_IDLE;
         count_ff <= '0;
      end else begin
         pc_ff    <= pc_in;
         count_ff <= count_in;
      end
   end

   // working registers of the current item
   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   // output register
   assign rsp_valid_in = rsp_load || out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= olidf_pkg::POS_W'(count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count          = rsp_count_ff;

   // count stays within the storage
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_x <= CMPW'(DEPTH))
      else $error("entry count above depth");

   // count moves only under a micro-op that owns it
   a_count_owner: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |->
         ($past(cw.op) == olidf_pkg::UOP_COUNT_CLR) ||
         ($past(cw.op) == olidf_pkg::UOP_COUNT_DEC) ||
         ($past(cw.op) == olidf_pkg::UOP_WRITE_APPEND) ||
         ($past(cw.op) == olidf_pkg::UOP_WRITE_VAL_POS))
      else $error("count changed outside its micro-ops");

   // a new result appears only from the respond step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cw.op) == olidf_pkg::UOP_RESPOND)
      else $error("result raised outside respond step");

   // a found position always comes with ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_found_ff != '0) |-> rsp_status_ff == olidf_pkg::ST_OK)
      else $error("found position with failing status");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// testbench for ordered_list_insert_delete_find: directed and phased random list requests,
// a scoreboard class predicts each response and checks it field by field
// depends on olidf_pkg and ordered_list_insert_delete_find
module tb_top;

   localparam int DEPTH        = olidf_pkg::DEPTH_DEFAULT;
   localparam int ACT_W        = olidf_pkg::ACT_W;
   localparam int VALUE_W      = olidf_pkg::VALUE_W;
   localparam int POS_W        = olidf_pkg::POS_W;
   localparam int STATUS_W     = olidf_pkg::STATUS_W;
   localparam int RANDOM_ITEMS = 1830;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

   localparam logic [ACT_W-1:0]          ACT_UNUSED_FIRST =
      ACT_W'(int'(olidf_pkg::ACT_FIND) + 1);
   localparam logic [ACT_W-1:0]          ACT_UNUSED_LAST  = {ACT_W{1'b1}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [POS_W-1:0]          POS_MAX   = {POS_W{1'b1}};

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_type;

   typedef struct {
      olidf_pkg::status_type status;
      logic [POS_W-1:0]      found_position;
      logic [POS_W-1:0]      count;
   } list_result_type;

   // list predictor plus queue of expected responses
   class list_scoreboard;
      logic signed [VALUE_W-1:0] entries [DEPTH];
      int unsigned               count;
      list_result_type           pending [$];
      int unsigned               errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      // apply one accepted item to the list and queue its response
      function void note_request(logic [ACT_W-1:0] action, logic signed [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] position);
         list_result_type r;
         int unsigned     i;
         r.status         = olidf_pkg::ST_OK;
         r.found_position = '0;
         case (action)
            olidf_pkg::ACT_CLEAR: begin
               count = 0;
            end
            olidf_pkg::ACT_APPEND: begin
               if (count >= DEPTH) begin
                  r.status = olidf_pkg::ST_FULL;
               end else begin
                  entries[count] = value;
                  count++;
               end
            end
            olidf_pkg::ACT_INSERT: begin
               // fullness wins over a bad position
               if (count >= DEPTH) begin
                  r.status = olidf_pkg::ST_FULL;
               end else if (position < 1 || position > count + 1) begin
                  r.status = olidf_pkg::ST_BADPOS;
               end else begin
                  for (i = count; i >= position; i--) entries[i] = entries[i-1];
                  entries[position-1] = value;
                  count++;
               end
            end
            olidf_pkg::ACT_DELETE: begin
               if (position < 1 || position > count) begin
                  r.status = olidf_pkg::ST_BADPOS;
               end else begin
                  for (i = position - 1; i + 1 < count; i++) entries[i] = entries[i+1];
                  count--;
               end
            end
            olidf_pkg::ACT_FIND: begin
               // first match wins
               r.status = olidf_pkg::ST_NOTFOUND;
               for (i = 0; i < count && r.status == olidf_pkg::ST_NOTFOUND; i++) begin
                  if (entries[i] == value) begin
                     r.found_position = POS_W'(i + 1);
                     r.status         = olidf_pkg::ST_OK;
                  end
               end
            end
            default: begin
            end
         endcase
         r.count = POS_W'(count);
         pending.push_back(r);
      endfunction

      // compare one accepted response with the oldest expectation
      function void check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] found_position,
                                 logic [POS_W-1:0] count_seen);
         list_result_type exp;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected: status %0d found %0d count %0d",
                     $time, status, found_position, count_seen);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
            errors++;
         end
         if (found_position !== exp.found_position) begin
            $display("%0t: found_position expected %0d actual %0d",
                     $time, exp.found_position, found_position);
            errors++;
         end
         if (count_seen !== exp.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp.count, count_seen);
            errors++;
         end
      endfunction
   endclass

   logic                        clock        = 1'b0;
   logic                        reset        = 1'b1;
   logic                        req_valid    = 1'b0;
   logic                        req_stall;
   logic [ACT_W-1:0]            req_action   = olidf_pkg::ACT_CLEAR;
   logic signed [VALUE_W-1:0]   req_value    = '0;
   logic [POS_W-1:0]            req_position = '0;
   logic                        rsp_valid;
   logic                        rsp_stall    = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic [POS_W-1:0]            rsp_found_position;
   logic [POS_W-1:0]            rsp_count;

   list_scoreboard list_sb;
   int unsigned    burst_left  = 0;
   int unsigned    stall_left  = 0;
   int unsigned    cycle_count = 0;

   ordered_list_insert_delete_find #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position),
      .rsp_count(rsp_count)
   );

   always #10 clock = ~clock;

   // idle length: mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 13);
   endfunction

   // small values repeat so find sees duplicates
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3, 4: return $signed($urandom_range(7)) - 4;
         default: return $signed($urandom);
      endcase
   endfunction

   // present one item and wait for its handshake
   task automatic send_item(input logic [ACT_W-1:0] action,
                            input logic signed [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position);
      int unsigned gap;
      gap = (burst_left > 0) ? 0 : pick_gap();
      if (burst_left > 0) begin
         burst_left--;
      end else if ($urandom_range(49) == 0) begin
         burst_left = $urandom_range(40, 10);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= action;
      req_value    <= value;
      req_position <= position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      list_sb.note_request(action, value, position);
   endtask

   // sender holds off until every expected response is in
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (list_sb.pending.size() > 0) @(posedge clock);
   endtask

   // one random item, weighted by phase; positions mostly legal for the current list
   task automatic send_random(input phase_type phase);
      int unsigned               held, roll, kind;
      int unsigned               t_app, t_ins, t_del, t_find;
      logic [ACT_W-1:0]          action;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
      held     = list_sb.count;
      value    = pick_value();
      position = POS_W'($urandom);
      roll     = $urandom_range(99);
      case (phase)
         PH_FILL:  begin t_app = 45; t_ins = 80; t_del = 87; t_find = 97; end
         PH_DRAIN: begin t_app = 10; t_ins = 20; t_del = 70; t_find = 88; end
         default:  begin t_app = 20; t_ins = 40; t_del = 65; t_find = 95; end
      endcase
      if (roll < t_app) begin
         action = olidf_pkg::ACT_APPEND;
      end else if (roll < t_ins) begin
         action   = olidf_pkg::ACT_INSERT;
         position = POS_W'($urandom_range(held + 1, 1));
      end else if (roll < t_del) begin
         action   = olidf_pkg::ACT_DELETE;
         position = (held == 0) ? POS_W'(1) : POS_W'($urandom_range(held, 1));
      end else if (roll < t_find) begin
         action = olidf_pkg::ACT_FIND;
         if (held > 0 && $urandom_range(9) < 7) value = list_sb.entries[$urandom_range(held - 1)];
      end else begin
         // noise: unused codes, illegal positions, rare clear
         kind = $urandom_range(19);
         if (kind < 9) begin
            action = ACT_W'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
         end else if (kind < 19) begin
            action = kind[0] ? olidf_pkg::ACT_INSERT : olidf_pkg::ACT_DELETE;
            if ($urandom_range(2) == 0) begin
               position = '0;
            end else begin
               position = POS_W'($urandom_range(POS_MAX,
                  held + (action == olidf_pkg::ACT_INSERT ? 2 : 1)));
            end
         end else begin
            action = olidf_pkg::ACT_CLEAR;
         end
      end
      send_item(action, value, position);
   endtask

   // response side stall pattern, with open stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left = ($urandom_range(99) < 30) ? $urandom_range(60, 10) : $urandom_range(4);
      end else if ($urandom_range(1) == 1) begin
         rsp_stall  <= 1'b1;
         stall_left = pick_gap();
      end else begin
         stall_left = $urandom_range(4);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         list_sb.check_result(rsp_status, rsp_found_position, rsp_count);
      end
   end

   // cycle limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned n, roll, phase_left;
      phase_type   phase;
      list_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, edges of positions, extremes of values, duplicates
      send_item(olidf_pkg::ACT_DELETE, 0, POS_W'(1));
      send_item(olidf_pkg::ACT_FIND, VALUE_MIN, POS_W'(0));
      send_item(olidf_pkg::ACT_INSERT, 7, POS_W'(0));
      send_item(olidf_pkg::ACT_INSERT, 7, POS_W'(2));
      send_item(olidf_pkg::ACT_INSERT, VALUE_MIN, POS_W'(1));
      send_item(olidf_pkg::ACT_APPEND, VALUE_MAX, POS_W'(0));
      send_item(olidf_pkg::ACT_APPEND, -1, POS_MAX);
      send_item(olidf_pkg::ACT_INSERT, 0, POS_W'(4));
      send_item(olidf_pkg::ACT_INSERT, 5, POS_W'(2));
      send_item(olidf_pkg::ACT_APPEND, 5, POS_W'(0));
      send_item(olidf_pkg::ACT_FIND, 5, POS_W'(0));
      send_item(olidf_pkg::ACT_FIND, 0, POS_W'(0));
      send_item(olidf_pkg::ACT_FIND, VALUE_MIN, POS_W'(0));
      send_item(olidf_pkg::ACT_FIND, 6, POS_W'(0));
      send_item(olidf_pkg::ACT_INSERT, 1, POS_W'(8));
      send_item(olidf_pkg::ACT_DELETE, 0, POS_W'(0));
      send_item(olidf_pkg::ACT_DELETE, 0, POS_W'(7));
      send_item(olidf_pkg::ACT_DELETE, 0, POS_MAX);
      send_item(olidf_pkg::ACT_DELETE, 0, POS_W'(6));
      send_item(olidf_pkg::ACT_DELETE, 0, POS_W'(1));
      send_item(olidf_pkg::ACT_FIND, 5, POS_W'(0));
      send_item(ACT_UNUSED_FIRST, VALUE_MAX, POS_MAX);
      send_item(ACT_W'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST)), VALUE_MIN,
                POS_W'(0));
      send_item(ACT_UNUSED_LAST, -1, POS_W'(1));
      send_item(olidf_pkg::ACT_CLEAR, VALUE_MAX, POS_MAX);
      send_item(olidf_pkg::ACT_FIND, 0, POS_W'(0));
      wait_for_drain();

      // random: a fill phase first so the full list is reached, then mixed phases
      phase      = PH_FILL;
      phase_left = 260;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            roll       = $urandom_range(99);
            phase      = (roll < 40) ? PH_FILL : (roll < 65) ? PH_DRAIN : PH_MIX;
            phase_left = $urandom_range(250, 100);
         end
         phase_left--;
         if ($urandom_range(99) == 0) wait_for_drain();
         send_random(phase);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (list_sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
